[hw/rtl/assert_macros.svh]
// assertion macros used by the rtl of the webp header parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define WPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition in one cycle implies a consequence in the next
`define WPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/wpd_pkg.sv]
// types, constants and helpers of the webp header dimension parser
`timescale 1ns / 1ps
`default_nettype none

package wpd_pkg;

  localparam int unsigned DIM_W      = 25;
  localparam int unsigned CHUNK_W    = 32;
  localparam int unsigned HEAD_BYTES = 10;
  localparam int unsigned SIG_BYTES  = 12;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_VP8  = 2'd1,
    KIND_VP8L = 2'd2,
    KIND_VP8X = 2'd3
  } kind_e;

  localparam logic [CHUNK_W-1:0] TAG_VP8  = 32'h5650_3820;
  localparam logic [CHUNK_W-1:0] TAG_VP8L = 32'h5650_384C;
  localparam logic [CHUNK_W-1:0] TAG_VP8X = 32'h5650_3858;

  localparam logic [7:0] VP8_SYNC0  = 8'h9d;
  localparam logic [7:0] VP8_SYNC1  = 8'h01;
  localparam logic [7:0] VP8_SYNC2  = 8'h2a;
  localparam logic [7:0] VP8L_SIG   = 8'h2f;
  localparam logic [13:0] VP8_DIM_MASK = 14'h3fff;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic  check;
    byte_t value;
  } sig_t;

  typedef struct packed {
    logic             ok;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  // expected file signature byte: "RIFF", size (not checked), "WEBP"
  function automatic sig_t sig_byte(input logic [3:0] idx);
    sig_t s;
    s = '{check: 1'b0, value: 8'h00};
    unique case (idx)
      4'd0:    s = '{check: 1'b1, value: 8'h52};
      4'd1:    s = '{check: 1'b1, value: 8'h49};
      4'd2:    s = '{check: 1'b1, value: 8'h46};
      4'd3:    s = '{check: 1'b1, value: 8'h46};
      4'd8:    s = '{check: 1'b1, value: 8'h57};
      4'd9:    s = '{check: 1'b1, value: 8'h45};
      4'd10:   s = '{check: 1'b1, value: 8'h42};
      4'd11:   s = '{check: 1'b1, value: 8'h50};
      default: s = '{check: 1'b0, value: 8'h00};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/wpd_dims.sv]
// width and height extraction and checks for an image chunk head
`timescale 1ns / 1ps
`default_nettype none

module wpd_dims
  import wpd_pkg::*;
(
  input  kind_e                      kind_i,
  input  logic [CHUNK_W-1:0]         chunk_len_i,
  input  byte_t [HEAD_BYTES-1:0]     head_i,
  output dims_t                      dims_o
);

  logic             valid;
  logic [DIM_W-1:0] w;
  logic [DIM_W-1:0] h;

  always_comb begin
    valid = 1'b0;
    w     = '0;
    h     = '0;
    case (kind_i)
      KIND_VP8: begin
        valid = (chunk_len_i >= CHUNK_W'(10)) && (head_i[3] == VP8_SYNC0) &&
                (head_i[4] == VP8_SYNC1) && (head_i[5] == VP8_SYNC2);
        w = DIM_W'({head_i[7], head_i[6]} & {2'b00, VP8_DIM_MASK});
        h = DIM_W'({head_i[9], head_i[8]} & {2'b00, VP8_DIM_MASK});
      end
      KIND_VP8L: begin
        valid = (chunk_len_i >= CHUNK_W'(5)) && (head_i[0] == VP8L_SIG);
        w = DIM_W'({head_i[2][5:0], head_i[1]}) + DIM_W'(1);
        h = DIM_W'({head_i[4][3:0], head_i[3], head_i[2][7:6]}) + DIM_W'(1);
      end
      KIND_VP8X: begin
        valid = chunk_len_i >= CHUNK_W'(10);
        w = DIM_W'({head_i[6], head_i[5], head_i[4]}) + DIM_W'(1);
        h = DIM_W'({head_i[9], head_i[8], head_i[7]}) + DIM_W'(1);
      end
      default: valid = 1'b0;
    endcase
  end

  // zero dimensions fail, failed results carry zero fields
  assign dims_o.ok     = valid && (w != '0) && (h != '0);
  assign dims_o.width  = dims_o.ok ? w : '0;
  assign dims_o.height = dims_o.ok ? h : '0;

endmodule

`default_nettype wire

[hw/rtl/webp_header_dimension_parser.sv]
// top level of the webp header dimension parser: chunk walker and result register
`timescale 1ns / 1ps
`default_nettype none

// Streams a WebP file one byte per transaction (last_i on the final byte) and
// returns exactly one result per file, one transaction issued with the final
// byte. The file must start with "RIFF" at offset 0 and "WEBP" at offset 8;
// the RIFF size field is ignored. Chunks are then walked by their 4-byte tag
// and little-endian 32-bit size; unknown chunks are skipped together with a
// pad byte when the size is odd. The first VP8, VP8L or VP8X chunk decides:
// its signature bytes, minimum size and nonzero dimensions are checked once
// its whole payload has arrived. Bytes after a decision are ignored, and any
// file that ends before a decision fails with ok_o low and all other result
// fields zero. Throughput is one byte per clock: each byte only steps a few
// counters and captures the first ten payload bytes of the image chunk, and
// the dimension extraction runs in the same cycle as the byte that completes
// it. The result appears on the cycle after the final byte is taken and is
// held in a single output register; in_ready_o drops only when a final byte
// arrives while the previous result has not been taken yet, so ordinary
// bytes keep flowing under output backpressure. LENGTH_BITS sets the width of
// the saturating byte position counter.
module webp_header_dimension_parser
  import wpd_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // byte stream
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             last_i,
  // result stream
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             ok_o,
  output logic [1:0]       kind_o,
  output logic [DIM_W-1:0] img_width_o,
  output logic [DIM_W-1:0] img_height_o
);

  // parse phases
  localparam logic [2:0] PH_FILE_HEAD  = 3'd0;
  localparam logic [2:0] PH_CHUNK_HEAD = 3'd1;
  localparam logic [2:0] PH_IMAGE      = 3'd2;
  localparam logic [2:0] PH_SKIP       = 3'd3;
  localparam logic [2:0] PH_DONE       = 3'd4;

  localparam int unsigned LEFT_W = CHUNK_W + 1;
  localparam int unsigned HCNT_W = $clog2(HEAD_BYTES + 1);
  localparam int unsigned HIDX_W = $clog2(HEAD_BYTES);

  // parse state
  logic [2:0]             phase_q, phase_d, phase_a;
  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  logic [CHUNK_W-1:0]     tag_q, tag_d;
  logic [CHUNK_W-1:0]     len_q, len_d;
  logic [LEFT_W-1:0]      left_q, left_d;
  logic [2:0]             hidx_q, hidx_d;
  logic [HCNT_W-1:0]      head_cnt_q, head_cnt_d;
  byte_t [HEAD_BYTES-1:0] head_q, head_d;
  kind_e                  kind_q, kind_d;
  logic                   failed_q, failed_d, failed_a;
  logic                   decide;

  // result register
  logic                   out_valid_q;
  logic                   out_ok_q;
  kind_e                  out_kind_q;
  logic [DIM_W-1:0]       out_w_q;
  logic [DIM_W-1:0]       out_h_q;

  logic                   in_acc;
  logic                   last_acc;
  logic                   res_ok;
  sig_t                   sig;
  kind_e                  tag_kind;
  logic [LEFT_W-1:0]      skip_len;
  dims_t                  dims;

  // only a final byte needs the result register free
  assign in_ready_o = out_ready_i || !out_valid_q || !last_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign last_acc   = in_acc && last_i;

  // tag lookup, tag is complete once the size bytes start
  always_comb begin
    unique case (tag_q)
      TAG_VP8:  tag_kind = KIND_VP8;
      TAG_VP8L: tag_kind = KIND_VP8L;
      TAG_VP8X: tag_kind = KIND_VP8X;
      default:  tag_kind = KIND_NONE;
    endcase
  end

  assign sig = sig_byte(pos_q[3:0]);

  // byte walker
  always_comb begin
    phase_a    = phase_q;
    failed_a   = failed_q;
    tag_d      = tag_q;
    len_d      = len_q;
    left_d     = left_q;
    hidx_d     = hidx_q;
    head_cnt_d = head_cnt_q;
    head_d     = head_q;
    kind_d     = kind_q;
    decide     = 1'b0;
    skip_len   = '0;

    unique case (phase_q)
      PH_FILE_HEAD: begin
        if (pos_q < LENGTH_BITS'(SIG_BYTES)) begin
          if (sig.check && (in_byte_i != sig.value)) begin
            failed_a = 1'b1;
            phase_a  = PH_DONE;
          end else if (pos_q[3:0] == 4'(SIG_BYTES - 1)) begin
            phase_a = PH_CHUNK_HEAD;
            hidx_d  = '0;
            tag_d   = '0;
            len_d   = '0;
          end
        end
      end

      PH_CHUNK_HEAD: begin
        hidx_d = hidx_q + 3'd1;
        if (!hidx_q[2]) begin
          tag_d = {tag_q[CHUNK_W-9:0], in_byte_i};
        end else begin
          len_d = len_q | (CHUNK_W'(in_byte_i) << {hidx_q[1:0], 3'b000});
        end
        if (hidx_q == 3'd7) begin
          if (tag_kind != KIND_NONE) begin
            kind_d     = tag_kind;
            left_d     = LEFT_W'(len_d);
            head_cnt_d = '0;
            phase_a    = PH_IMAGE;
            // empty image chunk is decided at once
            decide     = (len_d == '0);
          end else begin
            // odd sizes carry one pad byte
            skip_len = LEFT_W'(len_d) + LEFT_W'(len_d[0]);
            if (skip_len == '0) begin
              hidx_d = '0;
              tag_d  = '0;
              len_d  = '0;
            end else begin
              left_d  = skip_len;
              phase_a = PH_SKIP;
            end
          end
        end
      end

      PH_IMAGE: begin
        if (left_q == '0) begin
          decide = 1'b1;
        end else begin
          if (head_cnt_q < HCNT_W'(HEAD_BYTES)) begin
            head_d[head_cnt_q[HIDX_W-1:0]] = in_byte_i;
            head_cnt_d = head_cnt_q + HCNT_W'(1);
          end
          left_d = left_q - LEFT_W'(1);
          decide = (left_q == LEFT_W'(1));
        end
      end

      PH_SKIP: begin
        if (left_q != '0) begin
          left_d = left_q - LEFT_W'(1);
        end
        if (left_q <= LEFT_W'(1)) begin
          phase_a = PH_CHUNK_HEAD;
          hidx_d  = '0;
          tag_d   = '0;
          len_d   = '0;
        end
      end

      PH_DONE: begin
        // everything until the final byte is ignored
      end

      default: begin
        phase_a = PH_DONE;
        failed_a = 1'b1;
      end
    endcase
  end

  // dimension checks on the image chunk head as it will stand after this byte
  wpd_dims u_dims (
    .kind_i      (kind_d),
    .chunk_len_i (len_d),
    .head_i      (head_d),
    .dims_o      (dims)
  );

  assign phase_d  = decide ? PH_DONE : phase_a;
  assign failed_d = decide ? !dims.ok : failed_a;
  assign res_ok   = (phase_d == PH_DONE) && !failed_d;

  // saturating byte position
  assign pos_d = (pos_q == '1) ? pos_q : pos_q + LENGTH_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_FILE_HEAD;
      pos_q      <= '0;
      tag_q      <= '0;
      len_q      <= '0;
      left_q     <= '0;
      hidx_q     <= '0;
      head_cnt_q <= '0;
      kind_q     <= KIND_NONE;
      failed_q   <= 1'b0;
    end else if (in_acc) begin
      if (last_i) begin
        // every file starts from a clean state
        phase_q    <= PH_FILE_HEAD;
        pos_q      <= '0;
        tag_q      <= '0;
        len_q      <= '0;
        left_q     <= '0;
        hidx_q     <= '0;
        head_cnt_q <= '0;
        kind_q     <= KIND_NONE;
        failed_q   <= 1'b0;
      end else begin
        phase_q    <= phase_d;
        pos_q      <= pos_d;
        tag_q      <= tag_d;
        len_q      <= len_d;
        left_q     <= left_d;
        hidx_q     <= hidx_d;
        head_cnt_q <= head_cnt_d;
        kind_q     <= kind_d;
        failed_q   <= failed_d;
      end
    end
  end

  // captured payload bytes, only read after being written in the same chunk
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      head_q <= head_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, dims already zero when the checks fail
  always_ff @(posedge clk_i) begin
    if (last_acc) begin
      out_ok_q   <= res_ok;
      out_kind_q <= res_ok ? kind_d : KIND_NONE;
      out_w_q    <= res_ok ? dims.width : '0;
      out_h_q    <= res_ok ? dims.height : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_ok_q;
  assign kind_o       = out_kind_q;
  assign img_width_o  = out_w_q;
  assign img_height_o = out_h_q;

`include "assert_macros.svh"

  `WPD_ASSERT_NEXT(a_last_gives_result, last_acc, out_valid_o, "final byte gave no result")
  `WPD_ASSERT_NEXT(a_last_restarts, last_acc, (phase_q == PH_FILE_HEAD) && (pos_q == '0), "state not cleared after final byte")
  `WPD_ASSERT(a_ok_has_kind, (out_valid_o && ok_o) |-> (kind_o != KIND_NONE), "ok result without kind")
  `WPD_ASSERT(a_fail_is_zero, (out_valid_o && !ok_o) |-> ((kind_o == KIND_NONE) && (img_width_o == '0) && (img_height_o == '0)), "failed result carries data")
  `WPD_ASSERT(a_head_cnt_bound, head_cnt_q <= HCNT_W'(HEAD_BYTES), "payload capture count overran")

endmodule

`default_nettype wire
